// ===== design/rtpchk_pkg.sv =====
package rtpchk_pkg;

    // Widths of the result fields.
    localparam int PRES_W    = 62;
    localparam int OUT_CNT_W = 48;

    // Configuration register widths, indexes and reset values.
    localparam int PT_W      = 7;
    localparam int RATE_W    = 19;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_PAYLOAD_TYPE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_RATE  = 1'd1;
    localparam logic [PT_W-1:0]      PT_RESET         = 7'd96;
    localparam logic [RATE_W-1:0]    RATE_RESET       = 19'd48000;

    // Input command codes.
    localparam logic CMD_PACKET = 1'b0;
    localparam logic CMD_CLEAR  = 1'b1;

    // Header constants.
    localparam logic [1:0] RTP_VERSION = 2'd2;
    localparam int         SEQ_W       = 16;
    localparam int         TS_W        = 32;
    localparam int         LEN_W       = 16;

    // Nanoseconds per second, and the one-bit-per-cycle divider length.
    localparam logic [PRES_W-1:0] NS_PER_S  = 62'd1000000000;
    localparam int                DIV_STEPS = PRES_W;
    localparam int                STEP_W    = $clog2(DIV_STEPS);

    // Sequencer states, one-hot.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } t_state;

endpackage

// ===== design/rtp_packet_check_and_loss_count.sv =====
// RTP packet check and loss statistics.
// Input channel: i_valid / o_stall carry one transaction per packet header or
// clear command (i_command). A transaction is taken when i_valid is high and
// o_stall is low. Output channel: o_valid / i_stall carry one result per input
// transaction: the accepted and first-packet flags, the presentation time in
// ns and the five statistics counters after the update.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 = expected payload type, 1 = sample rate). The user must write only
// while the block is idle; the block itself does not enforce this.
// A clear, a rejected packet, a baseline packet or any packet while the
// sample rate is zero goes through the DONE state into the output register.
// An accepted packet with a baseline passes the multiply state, the
// restoring divider that retires one quotient bit per cycle, and DONE. The
// next transaction is taken once the result is in the output register.
// Reset clears all counters, the sequence and timestamp baseline and the
// link flag, and loads the configuration defaults. While the receiver holds
// i_stall a finished result waits in the output register, the sequencer
// waits with the following result, and o_stall stays high.
module rtp_packet_check_and_loss_count #(
    parameter int COUNTER_WIDTH = 48,
    parameter int MAX_PAYLOAD   = 1500
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // Configuration port
    input  logic                                 i_cfg_we,
    input  logic [rtpchk_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rtpchk_pkg::RATE_W-1:0]        i_cfg_data,
    // Input channel
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic                                 i_command,
    input  logic [1:0]                           i_header_version,
    input  logic [rtpchk_pkg::PT_W-1:0]          i_payload_type,
    input  logic [rtpchk_pkg::LEN_W-1:0]         i_payload_bytes,
    input  logic [rtpchk_pkg::SEQ_W-1:0]         i_sequence_number,
    input  logic [rtpchk_pkg::TS_W-1:0]          i_rtp_timestamp,
    // Output channel
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_accepted,
    output logic                                 o_first_packet,
    output logic [rtpchk_pkg::PRES_W-1:0]        o_presentation_ns,
    output logic [rtpchk_pkg::OUT_CNT_W-1:0]     o_packets_received,
    output logic [rtpchk_pkg::OUT_CNT_W-1:0]     o_packets_lost,
    output logic [rtpchk_pkg::OUT_CNT_W-1:0]     o_out_of_order,
    output logic [rtpchk_pkg::OUT_CNT_W-1:0]     o_malformed,
    output logic [rtpchk_pkg::OUT_CNT_W-1:0]     o_bytes_received
);

    // Saturating add of a narrow increment to a statistics counter.
    function automatic logic [COUNTER_WIDTH-1:0] f_sat_add(
        input logic [COUNTER_WIDTH-1:0]      a,
        input logic [rtpchk_pkg::LEN_W-1:0]  b
    );
        logic [COUNTER_WIDTH:0] s;
        s = {1'b0, a} + (COUNTER_WIDTH+1)'(b);
        return s[COUNTER_WIDTH] ? {COUNTER_WIDTH{1'b1}} : s[COUNTER_WIDTH-1:0];
    endfunction

    rtpchk_pkg::t_state r_state;

    // Configuration registers.
    logic [rtpchk_pkg::PT_W-1:0]   r_exp_pt;
    logic [rtpchk_pkg::RATE_W-1:0] r_sample_rate;

    // Statistics and stream state.
    logic [COUNTER_WIDTH-1:0]       r_rx_cnt, r_lost_cnt, r_reorder_cnt, r_bad_cnt, r_byte_cnt;
    logic [rtpchk_pkg::SEQ_W-1:0]   r_last_seq;
    logic [rtpchk_pkg::TS_W-1:0]    r_base_ts;
    logic                           r_base_valid;
    logic                           r_link_up;

    // Per-transaction flags.
    logic r_acc, r_first, r_div_en;

    // Divider datapath.
    logic [rtpchk_pkg::TS_W-1:0]    r_delta;
    logic [rtpchk_pkg::PRES_W-1:0]  r_quo;
    logic [rtpchk_pkg::RATE_W-1:0]  r_rem;
    logic [rtpchk_pkg::STEP_W-1:0]  r_step;

    // Output register.
    logic                              r_out_valid;
    logic                              r_o_acc, r_o_first;
    logic [rtpchk_pkg::PRES_W-1:0]     r_o_pres;
    logic [rtpchk_pkg::OUT_CNT_W-1:0]  r_o_rx, r_o_lost, r_o_reorder, r_o_bad, r_o_bytes;

    logic                              w_accept, w_pkt_ok, w_rate_on, w_load, w_take;
    logic [rtpchk_pkg::SEQ_W-1:0]      w_want, w_gap;
    logic [rtpchk_pkg::RATE_W:0]       w_trial, w_divisor;
    logic                              w_qbit;
    logic [rtpchk_pkg::RATE_W-1:0]     w_diff;

    // Handshake and packet validation.
    assign o_stall   = (r_state != rtpchk_pkg::ST_IDLE);
    assign w_accept  = i_valid && !o_stall;
    assign w_rate_on = (r_sample_rate != '0);
    assign w_pkt_ok  = (i_header_version == rtpchk_pkg::RTP_VERSION) &&
                       (i_payload_type == r_exp_pt) &&
                       (i_payload_bytes != '0) &&
                       (i_payload_bytes <= rtpchk_pkg::LEN_W'(MAX_PAYLOAD));

    // Sequence gap against the expected next sequence number, with 16-bit wrap.
    assign w_want = r_last_seq + 16'd1;
    assign w_gap  = i_sequence_number - w_want;

    // One restoring division step: shift in the next dividend bit and try to subtract.
    assign w_divisor = {1'b0, r_sample_rate};
    assign w_trial   = {r_rem, r_quo[rtpchk_pkg::PRES_W-1]};
    assign w_qbit    = (w_trial >= w_divisor);
    assign w_diff    = rtpchk_pkg::RATE_W'(w_trial - w_divisor);

    // Output register load and drain.
    assign w_load = (r_state == rtpchk_pkg::ST_DONE) && (!r_out_valid || !i_stall);
    assign w_take = r_out_valid && !i_stall;

    // Sequencer, configuration and statistics.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= rtpchk_pkg::ST_IDLE;
            r_exp_pt      <= rtpchk_pkg::PT_RESET;
            r_sample_rate <= rtpchk_pkg::RATE_RESET;
            r_rx_cnt      <= '0;
            r_lost_cnt    <= '0;
            r_reorder_cnt <= '0;
            r_bad_cnt     <= '0;
            r_byte_cnt    <= '0;
            r_last_seq    <= '0;
            r_base_ts     <= '0;
            r_base_valid  <= 1'b0;
            r_link_up     <= 1'b0;
            r_acc         <= 1'b0;
            r_first       <= 1'b0;
            r_div_en      <= 1'b0;
            r_step        <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    rtpchk_pkg::CFG_PAYLOAD_TYPE: r_exp_pt <= i_cfg_data[rtpchk_pkg::PT_W-1:0];
                    rtpchk_pkg::CFG_SAMPLE_RATE:  r_sample_rate <= i_cfg_data;
                    default: ;
                endcase
            end

            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (w_take) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                rtpchk_pkg::ST_IDLE: begin
                    if (w_accept) begin
                        r_acc    <= 1'b0;
                        r_first  <= 1'b0;
                        r_div_en <= 1'b0;
                        r_state  <= rtpchk_pkg::ST_DONE;
                        if (i_command == rtpchk_pkg::CMD_CLEAR) begin
                            r_rx_cnt      <= '0;
                            r_lost_cnt    <= '0;
                            r_reorder_cnt <= '0;
                            r_bad_cnt     <= '0;
                            r_byte_cnt    <= '0;
                            r_last_seq    <= '0;
                            r_base_ts     <= '0;
                            r_base_valid  <= 1'b0;
                        end else if (!w_pkt_ok) begin
                            r_bad_cnt <= f_sat_add(r_bad_cnt, 16'd1);
                        end else begin
                            r_acc     <= 1'b1;
                            r_first   <= !r_link_up;
                            r_link_up <= 1'b1;
                            // Gap check only once a packet has been counted.
                            if (r_rx_cnt != '0 && i_sequence_number != w_want) begin
                                if (!w_gap[rtpchk_pkg::SEQ_W-1]) begin
                                    r_lost_cnt <= f_sat_add(r_lost_cnt, w_gap);
                                end else begin
                                    r_reorder_cnt <= f_sat_add(r_reorder_cnt, 16'd1);
                                end
                            end
                            r_last_seq <= i_sequence_number;
                            r_rx_cnt   <= f_sat_add(r_rx_cnt, 16'd1);
                            r_byte_cnt <= f_sat_add(r_byte_cnt, i_payload_bytes);
                            // The first packet with a nonzero rate sets the baseline.
                            if (w_rate_on) begin
                                if (r_base_valid) begin
                                    r_div_en <= 1'b1;
                                    r_state  <= rtpchk_pkg::ST_MUL;
                                end else begin
                                    r_base_ts    <= i_rtp_timestamp;
                                    r_base_valid <= 1'b1;
                                end
                            end
                        end
                    end
                end
                rtpchk_pkg::ST_MUL: begin
                    r_step  <= '0;
                    r_state <= rtpchk_pkg::ST_DIV;
                end
                rtpchk_pkg::ST_DIV: begin
                    r_step <= r_step + rtpchk_pkg::STEP_W'(1);
                    if (r_step == rtpchk_pkg::STEP_W'(rtpchk_pkg::DIV_STEPS - 1)) begin
                        r_state <= rtpchk_pkg::ST_DONE;
                    end
                end
                rtpchk_pkg::ST_DONE: begin
                    if (w_load) begin
                        r_state <= rtpchk_pkg::ST_IDLE;
                    end
                end
                default: begin
                    r_state <= rtpchk_pkg::ST_IDLE;
                end
            endcase
        end
    end

    // Timestamp delta, product and divider registers.
    always_ff @(posedge i_clk) begin
        if (r_state == rtpchk_pkg::ST_IDLE) begin
            r_delta <= i_rtp_timestamp - r_base_ts;
        end
        if (r_state == rtpchk_pkg::ST_MUL) begin
            r_quo <= rtpchk_pkg::PRES_W'(r_delta) * rtpchk_pkg::NS_PER_S;
            r_rem <= '0;
        end else if (r_state == rtpchk_pkg::ST_DIV) begin
            r_quo <= {r_quo[rtpchk_pkg::PRES_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_diff : w_trial[rtpchk_pkg::RATE_W-1:0];
        end
    end

    // Result payload, taken from the updated statistics.
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_acc     <= r_acc;
            r_o_first   <= r_first;
            r_o_pres    <= r_div_en ? r_quo : '0;
            r_o_rx      <= rtpchk_pkg::OUT_CNT_W'(r_rx_cnt);
            r_o_lost    <= rtpchk_pkg::OUT_CNT_W'(r_lost_cnt);
            r_o_reorder <= rtpchk_pkg::OUT_CNT_W'(r_reorder_cnt);
            r_o_bad     <= rtpchk_pkg::OUT_CNT_W'(r_bad_cnt);
            r_o_bytes   <= rtpchk_pkg::OUT_CNT_W'(r_byte_cnt);
        end
    end

    assign o_valid            = r_out_valid;
    assign o_accepted         = r_o_acc;
    assign o_first_packet     = r_o_first;
    assign o_presentation_ns  = r_o_pres;
    assign o_packets_received = r_o_rx;
    assign o_packets_lost     = r_o_lost;
    assign o_out_of_order     = r_o_reorder;
    assign o_malformed        = r_o_bad;
    assign o_bytes_received   = r_o_bytes;

    // The divider only runs with a nonzero rate, and its remainder stays below it.
    a_div_rate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == rtpchk_pkg::ST_DIV) |-> (r_sample_rate != '0) && (r_rem < r_sample_rate))
        else $error("divider running with bad rate or remainder");

    // A result that is not an accepted packet carries no time and no first flag.
    a_reject_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_o_acc) |-> (r_o_pres == '0) && !r_o_first)
        else $error("rejected result carries presentation time or first flag");

    // A clear command leaves every counter and the baseline at zero.
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_command == rtpchk_pkg::CMD_CLEAR) |=>
        (r_rx_cnt == '0) && (r_lost_cnt == '0) && (r_reorder_cnt == '0) &&
        (r_bad_cnt == '0) && (r_byte_cnt == '0) && !r_base_valid)
        else $error("statistics not cleared");

    // A result is loaded only when the output register is free or draining.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |-> !w_load)
        else $error("stalled result overwritten");

endmodule
